FILE: design/dtm_pkg.sv
// shared types, codes and helpers of the differential temperature monitor
package dtm_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CAL_W = 22;
	localparam int Q_DEPTH = 2;

	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;

	localparam logic signed [11:0] CAL_TEMP_RESET = 12'sd320;
	localparam logic [31:0] HOLD_OFF_RESET = 32'd30000;
	localparam logic [15:0] TRIGGER_DELTA_RESET = 16'd80;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_HOLD_OFF = 2'd1,
		REG_TRIGGER_DELTA = 2'd2,
		REG_REFERENCE = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		EV_TRIP = 2'd0,
		EV_CLEAR = 2'd1,
		EV_ALL_NORMAL = 2'd2
	} event_t;

	typedef struct packed {
		logic enable;
		logic [31:0] hold_off;
		logic [15:0] trigger_delta;
		logic [2:0] ref_ch;
	} cfg_t;

	typedef struct packed {
		logic [2:0] channel;
		logic active;
		logic eval;
		logic above;
		logic last_of_pass;
		logic [31:0] now_ms;
	} q_entry_t;

	// cal_temp + (cal_raw - sample) / 2, rounded toward zero
	function automatic logic signed [12:0] temperature(
		input logic [9:0] cal_raw,
		input logic [9:0] sample,
		input logic signed [11:0] cal_temp
	);
		logic signed [10:0] d;
		logic signed [10:0] d_adj;
		logic signed [10:0] h;
		d = $signed({1'b0, cal_raw}) - $signed({1'b0, sample});
		d_adj = d + $signed({10'b0, d[10]});
		h = d_adj >>> 1;
		return $signed({cal_temp[11], cal_temp}) + $signed({{2{h[10]}}, h});
	endfunction

endpackage

FILE: design/dtm_ram.sv
// generic ram, one write port, two registered read ports
module dtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: design/dtm_front.sv
// front end: accepts items, stores calibration, computes the temperature difference
module dtm_front import dtm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	localparam int CH_W = $clog2(CHANNELS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    operation,
	input  logic [2:0]              channel,
	input  logic [9:0]              raw_sample,
	input  logic [9:0]              reference_sample,
	input  logic [31:0]             now_ms,
	input  logic signed [11:0]      calib_temperature,
	input  logic                    last_of_pass,
	output logic                    push_valid,
	output q_entry_t                push_data,
	input  logic                    push_ready
);

	logic [CHANNELS-1:0] cal_vld_q;
	logic accept, chk_acc, cal_acc, ch_ok, ref_ok, eval;
	logic [CH_W-1:0] ch_idx, ref_idx;
	logic [CAL_W-1:0] cal_ch, cal_ref;

	logic valid_s1, ch_vld_s1, ref_vld_s1, eval_s1, active_s1, last_s1;
	logic [2:0] ch_s1;
	logic [9:0] raw_s1, rsamp_s1;
	logic [31:0] now_s1;

	logic signed [11:0] ct_ch, ct_ref;
	logic signed [12:0] t_ch, t_ref;
	logic signed [13:0] delta;
	logic signed [16:0] delta_x, thr_x;

	assign in_ready = !valid_s1 || push_ready;
	assign accept = in_valid && in_ready;
	assign chk_acc = accept && (operation == OP_CHECK);
	assign ch_idx = CH_W'(channel);
	assign ref_idx = CH_W'(cfg.ref_ch);
	assign ch_ok = int'(channel) < CHANNELS;
	assign ref_ok = int'(cfg.ref_ch) < CHANNELS;
	assign cal_acc = accept && (operation == OP_CALIBRATE) && ch_ok;
	assign eval = ch_ok && ref_ok && (channel != cfg.ref_ch) && cfg.enable;

	dtm_ram #(
		.WIDTH(CAL_W),
		.DEPTH(CHANNELS)
	) u_cal_ram (
		.clk     (clk),
		.we      (cal_acc),
		.waddr   (ch_idx),
		.wdata   ({calib_temperature, raw_sample}),
		.re      (chk_acc),
		.raddr_a (ch_idx),
		.raddr_b (ref_idx),
		.rdata_a (cal_ch),
		.rdata_b (cal_ref)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_vld_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cal_acc) begin
				cal_vld_q[ch_idx] <= 1'b1;
			end
			if (chk_acc) begin
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk_acc) begin
			ch_s1 <= channel;
			raw_s1 <= raw_sample;
			rsamp_s1 <= reference_sample;
			now_s1 <= now_ms;
			last_s1 <= last_of_pass;
			eval_s1 <= eval;
			active_s1 <= cfg.enable;
			ch_vld_s1 <= cal_vld_q[ch_idx];
			ref_vld_s1 <= cal_vld_q[ref_idx];
		end
	end

	assign ct_ch = ch_vld_s1 ? $signed(cal_ch[21:10]) : CAL_TEMP_RESET;
	assign ct_ref = ref_vld_s1 ? $signed(cal_ref[21:10]) : CAL_TEMP_RESET;
	assign t_ch = temperature(cal_ch[9:0], raw_s1, ct_ch);
	assign t_ref = temperature(cal_ref[9:0], rsamp_s1, ct_ref);
	assign delta = $signed({t_ch[12], t_ch}) - $signed({t_ref[12], t_ref});
	assign delta_x = $signed({{3{delta[13]}}, delta});
	assign thr_x = $signed({cfg.trigger_delta[15], cfg.trigger_delta});

	assign push_valid = valid_s1;
	always_comb begin
		push_data.channel = ch_s1;
		push_data.active = active_s1;
		push_data.eval = eval_s1;
		push_data.above = delta_x > thr_x;
		push_data.last_of_pass = last_s1;
		push_data.now_ms = now_s1;
	end

endmodule

FILE: design/dtm_queue.sv
// two-entry queue between front and back end
module dtm_queue import dtm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  q_entry_t push_data,
	output logic     push_ready,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	q_entry_t slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, do_pop;

	assign push_ready = count_q != CW'(Q_DEPTH);
	assign head_valid = count_q != '0;
	assign head = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/dtm_back.sv
// back end: trip state, hold-off timers, event generation and output register
module dtm_back import dtm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	localparam int CH_W = $clog2(CHANNELS)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       head_valid,
	input  q_entry_t   head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [2:0] event_channel,
	output logic       last
);

	logic [CHANNELS-1:0] tripped_q, tripped_nx;
	logic [31:0] trip_time_q [CHANNELS];
	logic cleared_q, pend_q, out_valid_q, last_q;
	event_t ev_q;
	logic [2:0] ev_ch_q;

	logic [CH_W-1:0] ch_idx;
	logic [31:0] elapsed;
	logic hold_ok, do_trip, do_clear, ev1, any_tripped, all_normal, out_free, issue;

	assign ch_idx = CH_W'(head.channel);
	assign elapsed = head.now_ms - trip_time_q[ch_idx];
	assign hold_ok = head.active && head.eval && (elapsed >= cfg.hold_off);
	assign do_trip = hold_ok && !tripped_q[ch_idx] && head.above;
	assign do_clear = hold_ok && tripped_q[ch_idx] && !head.above;
	assign ev1 = do_trip || do_clear;

	always_comb begin
		tripped_nx = tripped_q;
		if (do_trip) begin
			tripped_nx[ch_idx] = 1'b1;
		end else if (do_clear) begin
			tripped_nx[ch_idx] = 1'b0;
		end
		any_tripped = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (tripped_nx[i] && (int'(cfg.ref_ch) != i)) begin
				any_tripped = 1'b1;
			end
		end
	end

	assign all_normal = head.active && head.last_of_pass && (cleared_q || do_clear)
		&& !any_tripped;
	assign out_free = !out_valid_q || out_ready;
	assign issue = head_valid && !pend_q && (out_free || !(ev1 || all_normal));
	assign pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tripped_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				trip_time_q[i] <= '0;
			end
			cleared_q <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				tripped_q <= tripped_nx;
				if (do_trip) begin
					trip_time_q[ch_idx] <= head.now_ms;
				end
				if (head.last_of_pass) begin
					cleared_q <= 1'b0;
				end else if (do_clear) begin
					cleared_q <= 1'b1;
				end
			end
			if (out_free) begin
				if (pend_q) begin
					out_valid_q <= 1'b1;
					pend_q <= 1'b0;
				end else if (issue && (ev1 || all_normal)) begin
					out_valid_q <= 1'b1;
					pend_q <= ev1 && all_normal;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				ev_q <= EV_ALL_NORMAL;
				ev_ch_q <= '0;
				last_q <= 1'b1;
			end else if (ev1) begin
				ev_q <= do_trip ? EV_TRIP : EV_CLEAR;
				ev_ch_q <= head.channel;
				last_q <= !all_normal;
			end else begin
				ev_q <= EV_ALL_NORMAL;
				ev_ch_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = ev_q;
	assign event_channel = ev_ch_q;
	assign last = last_q;

endmodule

FILE: design/differential_temperature_monitor.sv
// Differential temperature monitor. A check item is accepted every cycle while in_ready
// is high; it passes a calibration ram read stage, a two-entry queue and the trip-state
// stage, and its events are then registered in the output register. A check that both
// clears a channel and ends an all-normal pass gives two results, which the output
// register shows one after the other.
// Calibrate items are finished in the cycle they are accepted and give no result.
// Uncalibrated channels use calibration temperature 320; no clearing pass runs after reset.
module differential_temperature_monitor import dtm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [2:0]         channel,
	input  logic [9:0]         raw_sample,
	input  logic [9:0]         reference_sample,
	input  logic [31:0]        now_ms,
	input  logic signed [11:0] calib_temperature,
	input  logic               last_of_pass,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_res,
	output logic [2:0]         event_channel,
	output logic               last
);

	cfg_t cfg_q;
	logic push_valid, push_ready, head_valid, pop;
	q_entry_t push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.hold_off <= HOLD_OFF_RESET;
			cfg_q.trigger_delta <= TRIGGER_DELTA_RESET;
			cfg_q.ref_ch <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_HOLD_OFF: cfg_q.hold_off <= cfg_data;
				REG_TRIGGER_DELTA: cfg_q.trigger_delta <= cfg_data[15:0];
				REG_REFERENCE: cfg_q.ref_ch <= cfg_data[2:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dtm_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.channel           (channel),
		.raw_sample        (raw_sample),
		.reference_sample  (reference_sample),
		.now_ms            (now_ms),
		.calib_temperature (calib_temperature),
		.last_of_pass      (last_of_pass),
		.push_valid        (push_valid),
		.push_data         (push_data),
		.push_ready        (push_ready)
	);

	dtm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dtm_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_res     (event_res),
		.event_channel (event_channel),
		.last          (last)
	);

	// all-normal closes an item and names no channel
	a_all_normal_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_ALL_NORMAL) |-> last && (event_channel == 3'd0))
		else $error("all-normal result not last or has a channel");

	// a non-final result is a trip or clear and is followed by the all-normal item
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (event_res == EV_TRIP) || (event_res == EV_CLEAR))
		else $error("non-final result is not a channel event");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && (event_res == EV_ALL_NORMAL))
		else $error("second result missing after first");

	// pop is only raised while the queue holds an item
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule
